/* hw/rtl/dpc_pkg.sv */
// Shared types and constants for the point clustering block.
// No dependencies; used by the top level and dpc_dist, not by dpc_ram.
`default_nettype none

package dpc_pkg;

  // Default sizes handed to the top level parameters
  localparam int MaxPointsDef  = 1024;
  localparam int CoordBitsDef  = 16;

  // Fixed field widths
  localparam int EpsW     = 33;
  localparam int MinPtsW  = 11;
  localparam int CfgIdxW  = 1;
  localparam int RdIdxW   = 10;
  localparam int ClusW    = 11;
  localparam int LabelW   = 10;

  // Register reset values
  localparam logic [EpsW-1:0]    EpsReset    = 33'd6400;
  localparam logic [MinPtsW-1:0] MinPtsReset = 11'd3;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgEps    = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgMinPts = 1'b1;

  // Input action and output kind codes
  localparam logic ActLoad     = 1'b0;
  localparam logic ActRead     = 1'b1;
  localparam logic KindReport  = 1'b0;
  localparam logic KindLabel   = 1'b1;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RD,
    ST_CLR,
    ST_OUTER,
    ST_OUTER_CHK,
    ST_OUTER_Q,
    ST_RQ_C,
    ST_RQ_CW,
    ST_RQ_RUN,
    ST_PUSH_N,
    ST_PUSH_Q,
    ST_PUSH_CHK,
    ST_EXP,
    ST_EXP_P,
    ST_EXP_CHK,
    ST_EXP_Q
  } dpc_state_e;

endpackage

`default_nettype wire

/* hw/rtl/dbscan_point_clustering.sv */
// Top level of the DBSCAN point clustering block: stream ports, sequencer.
// Depends on dpc_pkg, dpc_ram and dpc_dist.
//
//  channel | dir | handshake              | payload
//  s_axis  | in  | tvalid/tready          | tuser action, tlast last, tdata points/index
//  m_axis  | out | tvalid/tready          | tuser kind, tdata counts and label
//  cfg     | in  | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// A load is stored straight away; a label read passes through ST_RD. The beat marked
// last runs the clustering: a sweep over all MAX_POINTS entries resets labels and queue
// marks, then every region query streams all loaded points through the one distance unit,
// and each neighbour push reads the neighbour list, then that point's label and mark.
// No beat is taken while clustering or while a result waits.
`default_nettype none

module dbscan_point_clustering #(
  parameter int MAX_POINTS = dpc_pkg::MaxPointsDef,
  parameter int COORD_BITS = dpc_pkg::CoordBitsDef
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // tdata: x_mm, y_mm, read_index, zero fill
  input  wire logic [((2*COORD_BITS+dpc_pkg::RdIdxW+7)/8)*8-1:0] s_axis_tdata,
  // tuser: action
  input  wire logic                               s_axis_tuser,
  input  wire logic                               s_axis_tlast,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // tdata: clusters_found, cluster_label, is_noise, point_index, overflow, zero fill
  output logic [39:0]                             m_axis_tdata,
  // tuser: kind
  output logic                                    m_axis_tuser,
  input  wire logic                               cfg_we_i,
  input  wire logic [dpc_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  wire logic [dpc_pkg::EpsW-1:0]           cfg_data_i
);

  localparam int IW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW  = $clog2(MAX_POINTS + 1);
  localparam int LW  = $clog2(MAX_POINTS + 2);
  localparam int CB  = COORD_BITS;
  localparam logic [LW-1:0] LblNoise = LW'(MAX_POINTS);
  localparam logic [LW-1:0] LblUnv   = LW'(MAX_POINTS + 1);
  localparam logic [IW-1:0] LastIdx  = IW'(MAX_POINTS - 1);

  // Input fields
  logic signed [CB-1:0]             in_x, in_y;
  logic [dpc_pkg::RdIdxW-1:0]       in_idx;
  assign in_x   = s_axis_tdata[CB-1:0];
  assign in_y   = s_axis_tdata[2*CB-1:CB];
  assign in_idx = s_axis_tdata[2*CB+dpc_pkg::RdIdxW-1:2*CB];

  // Control and data registers
  dpc_pkg::dpc_state_e state_q, state_d;
  logic [dpc_pkg::EpsW-1:0]    eps_q;
  logic [dpc_pkg::MinPtsW-1:0] minp_q;
  logic [CW-1:0] pc_q, pc_d, i_q, i_d, cc_q, cc_d, n_q, n_d;
  logic [CW-1:0] j_q, j_d, jr_q, jr_d, k_q, k_d, head_q, head_d, tail_q, tail_d;
  logic [IW-1:0] clr_q, clr_d, c_q, c_d;
  logic          ovf_q, ovf_d, done_q, done_d, exp_q, exp_d, iss_q, iss_d;
  logic [dpc_pkg::RdIdxW-1:0] ridx_q, ridx_d;
  logic signed [CB-1:0] xc_q, xc_d, yc_q, yc_d;
  logic          ov_q, ov_d;
  logic [39:0]   od_q, od_d;
  logic          ok_q, ok_d;

  // RAM ports
  logic          xy_we, lb_we, mk_we, mk_wd, sq_we, nl_we;
  logic [IW-1:0] xy_wa, xy_ra, lb_wa, lb_ra, mk_wa, mk_ra, sq_wa, sq_ra, nl_wa, nl_ra;
  logic [CB-1:0] x_rd, y_rd;
  logic [LW-1:0] lb_wd, lb_rd;
  logic          mk_rd;
  logic [IW-1:0] sq_wd, sq_rd, nl_wd, nl_rd;
  logic          hit_vld, hit;

  dpc_ram #(.Width(CB), .Depth(MAX_POINTS)) u_x_ram (
    .clk_i, .we_i(xy_we), .waddr_i(xy_wa), .wdata_i(in_x), .raddr_i(xy_ra), .rdata_o(x_rd));
  dpc_ram #(.Width(CB), .Depth(MAX_POINTS)) u_y_ram (
    .clk_i, .we_i(xy_we), .waddr_i(xy_wa), .wdata_i(in_y), .raddr_i(xy_ra), .rdata_o(y_rd));
  dpc_ram #(.Width(LW), .Depth(MAX_POINTS)) u_label_ram (
    .clk_i, .we_i(lb_we), .waddr_i(lb_wa), .wdata_i(lb_wd), .raddr_i(lb_ra), .rdata_o(lb_rd));
  dpc_ram #(.Width(1), .Depth(MAX_POINTS)) u_mark_ram (
    .clk_i, .we_i(mk_we), .waddr_i(mk_wa), .wdata_i(mk_wd), .raddr_i(mk_ra), .rdata_o(mk_rd));
  dpc_ram #(.Width(IW), .Depth(MAX_POINTS)) u_seed_ram (
    .clk_i, .we_i(sq_we), .waddr_i(sq_wa), .wdata_i(sq_wd), .raddr_i(sq_ra), .rdata_o(sq_rd));
  dpc_ram #(.Width(IW), .Depth(MAX_POINTS)) u_nbr_ram (
    .clk_i, .we_i(nl_we), .waddr_i(nl_wa), .wdata_i(nl_wd), .raddr_i(nl_ra), .rdata_o(nl_rd));

  dpc_dist #(.CoordBits(CB)) u_dist (
    .clk_i, .rst_ni, .in_vld_i(iss_q), .xc_i(xc_q), .yc_i(yc_q),
    .xr_i(x_rd), .yr_i(y_rd), .eps_i(eps_q), .out_vld_o(hit_vld), .out_hit_o(hit));

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q  <= dpc_pkg::EpsReset;
      minp_q <= dpc_pkg::MinPtsReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == dpc_pkg::CfgEps) begin
        eps_q <= cfg_data_i;
      end
      if (cfg_idx_i == dpc_pkg::CfgMinPts) begin
        minp_q <= cfg_data_i[dpc_pkg::MinPtsW-1:0];
      end
    end
  end

  // State and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dpc_pkg::ST_IDLE;
      pc_q <= '0; i_q <= '0; cc_q <= '0; n_q <= '0; j_q <= '0; jr_q <= '0;
      k_q <= '0; head_q <= '0; tail_q <= '0; clr_q <= '0;
      ovf_q <= 1'b0; done_q <= 1'b0; exp_q <= 1'b0; iss_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q <= pc_d; i_q <= i_d; cc_q <= cc_d; n_q <= n_d; j_q <= j_d; jr_q <= jr_d;
      k_q <= k_d; head_q <= head_d; tail_q <= tail_d; clr_q <= clr_d;
      ovf_q <= ovf_d; done_q <= done_d; exp_q <= exp_d; iss_q <= iss_d; ov_q <= ov_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    c_q <= c_d; xc_q <= xc_d; yc_q <= yc_d; ridx_q <= ridx_d; od_q <= od_d; ok_q <= ok_d;
  end

  // Next state, RAM control and results
  always_comb begin
    logic [CW-1:0] pc_eff;
    logic          idx_ok;
    state_d = state_q;
    pc_d = pc_q; i_d = i_q; cc_d = cc_q; n_d = n_q; j_d = j_q; jr_d = jr_q;
    k_d = k_q; head_d = head_q; tail_d = tail_q; clr_d = clr_q;
    ovf_d = ovf_q; done_d = done_q; exp_d = exp_q; iss_d = 1'b0;
    c_d = c_q; xc_d = xc_q; yc_d = yc_q; ridx_d = ridx_q;
    ov_d = ov_q; od_d = od_q; ok_d = ok_q;
    s_axis_tready = 1'b0;
    xy_we = 1'b0; xy_wa = pc_q[IW-1:0]; xy_ra = c_q;
    lb_we = 1'b0; lb_wa = c_q; lb_wd = LW'(cc_q); lb_ra = i_q[IW-1:0];
    mk_we = 1'b0; mk_wa = clr_q; mk_wd = 1'b0; mk_ra = nl_rd;
    sq_we = 1'b0; sq_wa = tail_q[IW-1:0]; sq_wd = nl_rd; sq_ra = head_q[IW-1:0];
    nl_we = 1'b0; nl_wa = n_q[IW-1:0]; nl_wd = jr_q[IW-1:0]; nl_ra = k_q[IW-1:0];
    pc_eff = done_q ? '0 : pc_q;
    idx_ok = done_q && (32'(ridx_q) < 32'(pc_q)) && (32'(ridx_q) < MAX_POINTS);

    // Drop the result once taken
    if (ov_q && m_axis_tready) begin
      ov_d = 1'b0;
    end

    case (state_q)
      dpc_pkg::ST_IDLE: begin
        s_axis_tready = !ov_q;
        lb_ra = IW'(in_idx);
        if (s_axis_tvalid && !ov_q) begin
          if (s_axis_tuser == dpc_pkg::ActRead) begin
            ridx_d  = in_idx;
            state_d = dpc_pkg::ST_RD;
          end else begin
            if (done_q) begin
              ovf_d  = 1'b0;
              done_d = 1'b0;
            end
            // Store the point or flag the drop
            if (32'(pc_eff) < MAX_POINTS) begin
              xy_we = 1'b1;
              xy_wa = pc_eff[IW-1:0];
              pc_d  = pc_eff + 1'b1;
            end else begin
              pc_d  = pc_eff;
              ovf_d = 1'b1;
            end
            if (s_axis_tlast) begin
              clr_d   = '0;
              state_d = dpc_pkg::ST_CLR;
            end
          end
        end
      end
      dpc_pkg::ST_RD: begin
        ov_d = 1'b1;
        ok_d = dpc_pkg::KindLabel;
        od_d = '0;
        od_d[10:0]  = 11'(cc_q);
        od_d[21]    = 1'b1;
        if (idx_ok && (lb_rd < LblNoise)) begin
          od_d[20:11] = 10'(lb_rd);
          od_d[21]    = 1'b0;
        end
        od_d[31:22] = ridx_q;
        od_d[32]    = ovf_q;
        state_d     = dpc_pkg::ST_IDLE;
      end
      dpc_pkg::ST_CLR: begin
        // Sweep labels to unvisited and marks to clear
        lb_we = 1'b1; lb_wa = clr_q; lb_wd = LblUnv;
        mk_we = 1'b1;
        clr_d = clr_q + 1'b1;
        if (clr_q == LastIdx) begin
          i_d = '0; cc_d = '0; exp_d = 1'b0;
          state_d = dpc_pkg::ST_OUTER;
        end
      end
      dpc_pkg::ST_OUTER: begin
        if (i_q == pc_q) begin
          done_d = 1'b1;
          ov_d = 1'b1;
          ok_d = dpc_pkg::KindReport;
          od_d = '0;
          od_d[10:0] = 11'(cc_q);
          od_d[32]   = ovf_q;
          state_d = dpc_pkg::ST_IDLE;
        end else begin
          state_d = dpc_pkg::ST_OUTER_CHK;
        end
      end
      dpc_pkg::ST_OUTER_CHK: begin
        if (lb_rd != LblUnv) begin
          i_d = i_q + 1'b1;
          state_d = dpc_pkg::ST_OUTER;
        end else begin
          c_d = i_q[IW-1:0];
          state_d = dpc_pkg::ST_RQ_C;
        end
      end
      dpc_pkg::ST_RQ_C: begin
        state_d = dpc_pkg::ST_RQ_CW;
      end
      dpc_pkg::ST_RQ_CW: begin
        xc_d = x_rd; yc_d = y_rd;
        j_d = '0; jr_d = '0; n_d = '0;
        state_d = dpc_pkg::ST_RQ_RUN;
      end
      dpc_pkg::ST_RQ_RUN: begin
        // Stream every point through the distance unit
        xy_ra = j_q[IW-1:0];
        if (j_q != pc_q) begin
          iss_d = 1'b1;
          j_d = j_q + 1'b1;
        end
        if (hit_vld) begin
          jr_d = jr_q + 1'b1;
          if (hit) begin
            nl_we = 1'b1;
            n_d = n_q + 1'b1;
          end
        end
        if (jr_q == pc_q) begin
          state_d = exp_q ? dpc_pkg::ST_EXP_Q : dpc_pkg::ST_OUTER_Q;
        end
      end
      dpc_pkg::ST_OUTER_Q: begin
        if (32'(n_q) < 32'(minp_q)) begin
          lb_we = 1'b1; lb_wd = LblNoise;
          i_d = i_q + 1'b1;
          state_d = dpc_pkg::ST_OUTER;
        end else begin
          lb_we = 1'b1;
          mk_we = 1'b1; mk_wa = c_q; mk_wd = 1'b1;
          head_d = '0; tail_d = '0; k_d = '0; exp_d = 1'b1;
          state_d = dpc_pkg::ST_PUSH_N;
        end
      end
      dpc_pkg::ST_PUSH_N: begin
        state_d = (k_q == n_q) ? dpc_pkg::ST_EXP : dpc_pkg::ST_PUSH_Q;
      end
      dpc_pkg::ST_PUSH_Q: begin
        lb_ra = nl_rd;
        state_d = dpc_pkg::ST_PUSH_CHK;
      end
      dpc_pkg::ST_PUSH_CHK: begin
        // Queue unvisited or noise neighbours once
        if ((lb_rd == LblUnv || lb_rd == LblNoise) && !mk_rd &&
            (32'(tail_q) < MAX_POINTS)) begin
          mk_we = 1'b1; mk_wa = nl_rd; mk_wd = 1'b1;
          sq_we = 1'b1;
          tail_d = tail_q + 1'b1;
        end
        k_d = k_q + 1'b1;
        state_d = dpc_pkg::ST_PUSH_N;
      end
      dpc_pkg::ST_EXP: begin
        if (head_q == tail_q) begin
          cc_d = cc_q + 1'b1;
          i_d = i_q + 1'b1;
          exp_d = 1'b0;
          state_d = dpc_pkg::ST_OUTER;
        end else begin
          state_d = dpc_pkg::ST_EXP_P;
        end
      end
      dpc_pkg::ST_EXP_P: begin
        // Hold the seed read address until the entry is latched, then advance
        lb_ra = sq_rd;
        head_d = head_q + 1'b1;
        state_d = dpc_pkg::ST_EXP_CHK;
      end
      dpc_pkg::ST_EXP_CHK: begin
        lb_wa = sq_rd;
        if (lb_rd == LblNoise) begin
          lb_we = 1'b1;
          state_d = dpc_pkg::ST_EXP;
        end else if (lb_rd != LblUnv) begin
          state_d = dpc_pkg::ST_EXP;
        end else begin
          lb_we = 1'b1;
          c_d = sq_rd;
          state_d = dpc_pkg::ST_RQ_C;
        end
      end
      dpc_pkg::ST_EXP_Q: begin
        k_d = '0;
        state_d = (32'(n_q) < 32'(minp_q)) ? dpc_pkg::ST_EXP : dpc_pkg::ST_PUSH_N;
      end
      default: begin
        state_d = dpc_pkg::ST_IDLE;
      end
    endcase
  end

  // Result beat
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;
  assign m_axis_tuser  = ok_q;

endmodule

`default_nettype wire

/* hw/rtl/dpc_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module dpc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                     wdata_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                     rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* hw/rtl/dpc_dist.sv */
// Pipelined squared-distance test shared by every region query.
// Depends on dpc_pkg for the radius width.
`default_nettype none

module dpc_dist #(
  parameter int CoordBits = dpc_pkg::CoordBitsDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_vld_i,
  input  wire logic signed [CoordBits-1:0] xc_i,
  input  wire logic signed [CoordBits-1:0] yc_i,
  input  wire logic signed [CoordBits-1:0] xr_i,
  input  wire logic signed [CoordBits-1:0] yr_i,
  input  wire logic [dpc_pkg::EpsW-1:0]    eps_i,
  output logic                             out_vld_o,
  output logic                             out_hit_o
);

  localparam int DW   = CoordBits + 1;
  localparam int SqW  = 2 * DW;
  localparam int SumW = SqW + 1;
  localparam int CmpW = (SumW > dpc_pkg::EpsW) ? SumW : dpc_pkg::EpsW;

  logic              v1_q, v2_q;
  logic signed [DW-1:0] dx_q, dy_q;
  logic [SqW-1:0]    sqx_q, sqy_q;
  logic [SumW-1:0]   sum;

  // Valid pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= in_vld_i;
      v2_q <= v1_q;
    end
  end

  // Differences, then squares at full width
  always_ff @(posedge clk_i) begin
    dx_q  <= DW'(xc_i) - DW'(xr_i);
    dy_q  <= DW'(yc_i) - DW'(yr_i);
    sqx_q <= $unsigned(SqW'(dx_q) * SqW'(dx_q));
    sqy_q <= $unsigned(SqW'(dy_q) * SqW'(dy_q));
  end

  // Sum and compare against the radius
  assign sum       = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign out_vld_o = v2_q;
  assign out_hit_o = CmpW'(sum) <= CmpW'(eps_i);

endmodule

`default_nettype wire

/* verif/tb_dbscan_point_clustering.sv */
// Self-checking testbench for dbscan_point_clustering: point frames, label reads,
// register writes, random stalls on both streams. Depends on dpc_pkg and the RTL.
`timescale 1ns / 1ps

typedef struct {
  bit        kind;
  bit [10:0] clusters;
  bit [9:0]  label;
  bit        noise;
  bit [9:0]  index;
  bit        ovf;
} dpc_result_t;

// Predicts cluster reports and label replies and checks each result beat
class cluster_scoreboard;
  localparam int Cap = dpc_pkg::MaxPointsDef;
  localparam int LblNoise = Cap;
  localparam int LblFresh = Cap + 1;

  dpc_result_t   pending_q[$];
  int            errors;
  longint        eps_sq;
  int            min_pts;
  int            xs[Cap];
  int            ys[Cap];
  int            lbl[Cap];
  int            seeds[Cap];
  bit            queued[Cap];
  int            nbr[Cap];
  int            n_pts;
  int            n_clusters;
  bit            ovf_flag;
  bit            clustered;

  function new();
    eps_sq = dpc_pkg::EpsReset;
    min_pts = dpc_pkg::MinPtsReset;
  endfunction

  function void set_reg(logic [dpc_pkg::CfgIdxW-1:0] idx, longint val);
    if (idx == dpc_pkg::CfgEps) eps_sq = val & 64'h1_FFFF_FFFF;
    else min_pts = val & 11'h7FF;
  endfunction

  function int neighbours(int c);
    longint dx, dy;
    int n;
    n = 0;
    for (int j = 0; j < n_pts; j++) begin
      dx = xs[c] - xs[j];
      dy = ys[c] - ys[j];
      if (dx * dx + dy * dy <= eps_sq) begin
        nbr[n] = j;
        n++;
      end
    end
    return n;
  endfunction

  function int push_seeds(int n, int tail);
    int q;
    for (int k = 0; k < n; k++) begin
      q = nbr[k];
      if ((lbl[q] == LblFresh || lbl[q] == LblNoise) && !queued[q] && tail < Cap) begin
        queued[q] = 1;
        seeds[tail] = q;
        tail++;
      end
    end
    return tail;
  endfunction

  function void cluster_frame();
    int n, head, tail, p;
    for (int i = 0; i < Cap; i++) begin
      queued[i] = 0;
      lbl[i] = LblFresh;
    end
    n_clusters = 0;
    for (int i = 0; i < n_pts; i++) begin
      if (lbl[i] != LblFresh) continue;
      n = neighbours(i);
      if (n < min_pts) begin
        lbl[i] = LblNoise;
        continue;
      end
      lbl[i] = n_clusters;
      queued[i] = 1;
      head = 0;
      tail = push_seeds(n, 0);
      while (head < tail) begin
        p = seeds[head];
        head++;
        if (lbl[p] == LblNoise) begin
          lbl[p] = n_clusters;
          continue;
        end
        if (lbl[p] != LblFresh) continue;
        lbl[p] = n_clusters;
        n = neighbours(p);
        if (n >= min_pts) tail = push_seeds(n, tail);
      end
      n_clusters++;
    end
    clustered = 1;
  endfunction

  // Note an accepted input beat and queue what it should produce
  function void note_beat(bit act, logic signed [15:0] x, logic signed [15:0] y,
                          bit lst, bit [9:0] idx);
    dpc_result_t r;
    if (act == dpc_pkg::ActLoad) begin
      if (clustered) begin
        n_pts = 0;
        ovf_flag = 0;
        clustered = 0;
      end
      if (n_pts < Cap) begin
        xs[n_pts] = x;
        ys[n_pts] = y;
        n_pts++;
      end else begin
        ovf_flag = 1;
      end
      if (!lst) return;
      cluster_frame();
      r = '{dpc_pkg::KindReport, n_clusters[10:0], 10'd0, 1'b0, 10'd0, ovf_flag};
    end else begin
      r = '{dpc_pkg::KindLabel, n_clusters[10:0], 10'd0, 1'b1, idx, ovf_flag};
      if (clustered && idx < n_pts && lbl[idx] < LblNoise) begin
        r.label = lbl[idx][9:0];
        r.noise = 0;
      end
    end
    pending_q.push_back(r);
  endfunction

  // Check one result beat against the oldest expectation
  function void check_beat(logic [39:0] data, logic kind);
    dpc_result_t e;
    if (pending_q.size() == 0) begin
      $error("unexpected result beat: tdata %h kind %0d", data, kind);
      errors++;
      return;
    end
    e = pending_q.pop_front();
    if (kind !== e.kind) begin
      $error("kind: expected %0d, got %0d", e.kind, kind); errors++;
    end
    if (data[10:0] !== e.clusters) begin
      $error("clusters_found: expected %0d, got %0d", e.clusters, data[10:0]); errors++;
    end
    if (data[20:11] !== e.label) begin
      $error("cluster_label: expected %0d, got %0d", e.label, data[20:11]); errors++;
    end
    if (data[21] !== e.noise) begin
      $error("is_noise: expected %0d, got %0d", e.noise, data[21]); errors++;
    end
    if (data[31:22] !== e.index) begin
      $error("point_index: expected %0d, got %0d", e.index, data[31:22]); errors++;
    end
    if (data[32] !== e.ovf) begin
      $error("overflow: expected %0d, got %0d", e.ovf, data[32]); errors++;
    end
  endfunction
endclass

module tb_dbscan_point_clustering;
  import dpc_pkg::*;

  localparam int CycleLimit = 12_000_000;
  localparam longint EpsTop = 64'd8589672450;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [EpsW-1:0]    cfg_data_i = '0;

  cluster_scoreboard sb = new();
  bit     gaps_on = 1'b1;
  bit     hold_req = 1'b0;
  int     beats_sent = 0;
  longint cycles = 0;

  dbscan_point_clustering uut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Check every result beat
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_beat(m_axis_tdata, m_axis_tuser);
  end

  // Receiver: random back-pressure, with one long hold on request
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = hold_req ? 400 : (gaps_on ? $urandom_range(0, 13) : 0);
      hold_req = 1'b0;
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  task automatic send_beat(bit act, logic signed [15:0] x, logic signed [15:0] y,
                           bit lst, bit [9:0] idx);
    int gap;
    gap = gaps_on ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tlast  <= lst;
    s_axis_tdata  <= {6'd0, idx, y, x};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_beat(act, x, y, lst, idx);
    beats_sent++;
  endtask

  task automatic load_pt(logic signed [15:0] x, logic signed [15:0] y, bit lst);
    send_beat(ActLoad, x, y, lst, $urandom_range(0, 1023));
  endtask

  task automatic read_pt(bit [9:0] idx);
    send_beat(ActRead, $urandom, $urandom, $urandom_range(0, 1), idx);
  endtask

  // Wait until the block is idle with nothing outstanding
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, longint val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val[EpsW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  // One random frame of clustered points, then some label reads
  task automatic random_frame();
    int n, r, cx, cy;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 60) : $urandom_range(1, 24);
    r = $isunknown(sb.eps_sq) ? 80 : 1;
    r = (sb.eps_sq > 64'd40000) ? 200 : 1 + $urandom_range(0, 200);
    cx = $urandom_range(0, 60000) - 30000;
    cy = $urandom_range(0, 60000) - 30000;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        load_pt($urandom, $urandom, i == n - 1);
      end else begin
        if ($urandom_range(0, 5) == 0) begin
          cx = $urandom_range(0, 60000) - 30000;
          cy = $urandom_range(0, 60000) - 30000;
        end
        load_pt(cx + $urandom_range(0, 2 * r) - r, cy + $urandom_range(0, 2 * r) - r,
                i == n - 1);
      end
      if (i != n - 1 && $urandom_range(0, 15) == 0) read_pt($urandom_range(0, 1023));
    end
    repeat ($urandom_range(2, 10)) begin
      if ($urandom_range(0, 4) == 0) read_pt($urandom_range(0, 1023));
      else read_pt($urandom_range(0, n - 1));
    end
  endtask

  initial begin
    int phase;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, two tight groups, reset settings
    load_pt(-16'sd32768, -16'sd32768, 1'b0);
    load_pt(16'sd32767, 16'sd32767, 1'b0);
    load_pt(0, 0, 1'b0);
    load_pt(10, 0, 1'b0);
    load_pt(0, 10, 1'b0);
    load_pt(500, 500, 1'b0);
    load_pt(520, 500, 1'b0);
    load_pt(500, 520, 1'b1);
    for (int i = 0; i < 8; i++) read_pt(i);
    read_pt(8);
    read_pt(10'd1023);
    settle();

    // Zero radius, single-point cores
    write_reg(CfgEps, 0);
    write_reg(CfgMinPts, 1);
    load_pt(7, 7, 1'b0);
    load_pt(7, 7, 1'b0);
    load_pt(-7, 7, 1'b1);
    read_pt(0); read_pt(2);
    settle();

    // Zero min_points behaves as one; widest radius with the largest min_points
    write_reg(CfgMinPts, 0);
    load_pt(1, 2, 1'b1);
    read_pt(0);
    settle();
    write_reg(CfgEps, EpsTop);
    write_reg(CfgMinPts, 1024);
    load_pt(-16'sd32768, 16'sd32767, 1'b0);
    load_pt(16'sd32767, -16'sd32768, 1'b1);
    read_pt(1);
    settle();

    // Full frame plus one dropped point, all noise under zero radius
    write_reg(CfgEps, 0);
    write_reg(CfgMinPts, 2);
    gaps_on = 1'b0;
    for (int i = 0; i <= 1024; i++) load_pt(i, -i, i == 1024);
    read_pt(10'd1023); read_pt(0);
    settle();
    gaps_on = 1'b1;

    // Random frames under changing settings
    phase = 0;
    while (beats_sent < 1025 + 50 + 580) begin
      case ($urandom_range(0, 5))
        0: write_reg(CfgEps, EpsTop + $urandom_range(0, 1));
        1: write_reg(CfgEps, 0);
        default: begin
          write_reg(CfgEps, $urandom_range(1, 250) ** 2);
        end
      endcase
      case ($urandom_range(0, 7))
        0: write_reg(CfgMinPts, 1024);
        1: write_reg(CfgMinPts, 1);
        default: write_reg(CfgMinPts, $urandom_range(2, 6));
      endcase
      gaps_on = (phase % 5) != 3;
      random_frame();
      if (phase == 6) begin
        // Receiver stalls long while reads keep arriving
        hold_req = 1'b1;
        repeat (16) read_pt($urandom_range(0, 1023));
      end
      settle();
      phase++;
    end

    repeat (50) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
